/* rtl/bim_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bim_pkg
// Shared widths, register indexes and the reciprocal table of the bilinear
// integer magnifier.
// ----------------------------------------------------------------------------
package bim_pkg;

	localparam int PIXEL_W     = 16;
	localparam int PHASE_W     = 3;
	localparam int POS_W       = 12;
	localparam int MAG_W       = 4;
	localparam int LW_W        = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;

	localparam int DEF_MAX_LINE_WIDTH = 4096;
	localparam logic [MAG_W-1:0] MAX_MAGNIFICATION = 4'd8;
	localparam logic [MAG_W-1:0] RESET_MAGNIFICATION = 4'd2;
	localparam logic [LW_W-1:0]  RESET_LINE_WIDTH = 13'd4096;
	localparam logic [POS_W-1:0] ROW_LIMIT = 12'd4095;

	// weight sum of one output: at most 65535 * 64 + 32, below 2^22
	localparam int WGT_W  = 7;
	localparam int ACC_W  = 22;
	localparam int HALF_W = 11;
	localparam int RC_W   = 23;
	localparam int Q_SHIFT = 22;

	localparam logic [CFG_IDX_W-1:0] REG_MAGNIFICATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 2'd1;

	// floor(2^22 / (m*m)); the quotient estimate is then low by at most one
	function automatic logic [RC_W-1:0] recip_for(input logic [MAG_W-1:0] m);
		logic [RC_W-1:0] r;
		case (m)
			4'd1: r = 23'd4194304;
			4'd2: r = 23'd1048576;
			4'd3: r = 23'd466033;
			4'd4: r = 23'd262144;
			4'd5: r = 23'd167772;
			4'd6: r = 23'd116508;
			4'd7: r = 23'd85598;
			4'd8: r = 23'd65536;
			default: r = 23'd4194304;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/bim_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bim_if
// Valid/ready channels of the magnifier: source pixels in, magnified pixels out.
// ----------------------------------------------------------------------------
interface bim_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [bim_pkg::PIXEL_W-1:0]  pixel_value;
	logic                         frame_start;

	modport source (output valid, output pixel_value, output frame_start, input ready);
	modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface bim_result_if;
	logic                         valid;
	logic                         ready;
	logic [bim_pkg::PIXEL_W-1:0]  out_value;
	logic [bim_pkg::PHASE_W-1:0]  line_phase;
	logic [bim_pkg::PHASE_W-1:0]  sample_phase;
	logic [bim_pkg::POS_W-1:0]    block_line;
	logic [bim_pkg::POS_W-1:0]    block_sample;
	logic                         last_of_block;

	modport source (output valid, output out_value, output line_phase, output sample_phase,
		output block_line, output block_sample, output last_of_block, input ready);
	modport sink   (input valid, input out_value, input line_phase, input sample_phase,
		input block_line, input block_sample, input last_of_block, output ready);
endinterface
`default_nettype wire

/* rtl/bilinear_integer_magnifier.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_integer_magnifier
// Line-store bilinear magnifier: each pixel completing a 2x2 window yields an
// M by M block, driven by a three-step microprogram and a seven-stage datapath.
// ----------------------------------------------------------------------------
//  channel     dir  transaction                     payload
//  pixels      in   one source pixel, raster order  pixel_value, frame_start
//  magnified   out  one interpolated pixel          out_value, phases, block pos
//  cfg write   in   one register write              reg_index, write_data
//
//  A pixel completing a window goes through take, window load and one issue
//  per output; any other pixel through take and load only. Results then pass
//  the seven datapath stages. A stalled output freezes the datapath and the
//  issue step; pixels are still taken while results wait. Reset clears
//  positions, neighbours and config; the line store is not cleared.
// ----------------------------------------------------------------------------
module bilinear_integer_magnifier #(
	parameter int MAX_LINE_WIDTH = bim_pkg::DEF_MAX_LINE_WIDTH
) (
	input  wire                               clk,
	input  wire                               arst_n,
	bim_pixel_if.sink                         pixels,
	bim_result_if.source                      magnified,
	input  wire                               write_enable,
	input  wire [bim_pkg::CFG_IDX_W-1:0]      reg_index,
	input  wire [bim_pkg::CFG_DATA_W-1:0]     write_data
);

	localparam int CW     = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 1;
	localparam int CMP_W  = (CW + 1 > bim_pkg::LW_W) ? CW + 1 : bim_pkg::LW_W;
	localparam int SUM_W  = bim_pkg::ACC_W + 2;
	localparam int PP_W   = bim_pkg::HALF_W + bim_pkg::RC_W;
	localparam int TOT_W  = PP_W + bim_pkg::HALF_W + 1;
	localparam int PX     = bim_pkg::PIXEL_W;
	localparam int MW     = bim_pkg::MAG_W;
	localparam int PW     = bim_pkg::PHASE_W;

	typedef enum logic [1:0] {ST_TAKE, ST_LOAD, ST_EMIT} step_t;
	typedef enum logic [1:0] {CD_ACCEPT, CD_WINDOW, CD_LAST} cond_t;

	typedef struct packed {
		logic  take;
		logic  load;
		logic  issue;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} uword_t;

	typedef struct packed {
		logic [PW-1:0]              i;
		logic [PW-1:0]              j;
		logic [bim_pkg::POS_W-1:0]  row;
		logic [bim_pkg::POS_W-1:0]  col;
		logic                       last;
	} tag_t;

	// configuration
	logic [MW-1:0]              mag_q;
	logic [bim_pkg::LW_W-1:0]   lw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= bim_pkg::RESET_MAGNIFICATION;
			lw_q  <= bim_pkg::RESET_LINE_WIDTH;
		end else if (write_enable) begin
			case (reg_index)
				bim_pkg::REG_MAGNIFICATION: mag_q <= write_data[MW-1:0];
				bim_pkg::REG_LINE_WIDTH:    lw_q  <= write_data[bim_pkg::LW_W-1:0];
				default: ;
			endcase
		end
	end

	logic [MW-1:0]    mag_eff;
	logic [CMP_W-1:0] lw_ext;
	logic [CMP_W-1:0] w_eff;

	always_comb begin
		if (mag_q == '0)
			mag_eff = MW'(1);
		else if (mag_q > bim_pkg::MAX_MAGNIFICATION)
			mag_eff = bim_pkg::MAX_MAGNIFICATION;
		else
			mag_eff = mag_q;
		lw_ext = CMP_W'(lw_q);
		if (lw_ext < CMP_W'(2))
			w_eff = CMP_W'(2);
		else if (lw_ext > CMP_W'(MAX_LINE_WIDTH))
			w_eff = CMP_W'(MAX_LINE_WIDTH);
		else
			w_eff = lw_ext;
	end

	// microprogram
	step_t  pc_q;
	uword_t uw;

	always_comb begin
		case (pc_q)
			ST_TAKE: uw = '{take: 1'b1, load: 1'b0, issue: 1'b0, cond: CD_ACCEPT,
				tgt_t: ST_LOAD, tgt_f: ST_TAKE};
			ST_LOAD: uw = '{take: 1'b0, load: 1'b1, issue: 1'b0, cond: CD_WINDOW,
				tgt_t: ST_EMIT, tgt_f: ST_TAKE};
			ST_EMIT: uw = '{take: 1'b0, load: 1'b0, issue: 1'b1, cond: CD_LAST,
				tgt_t: ST_TAKE, tgt_f: ST_EMIT};
			default: uw = '{take: 1'b0, load: 1'b0, issue: 1'b0, cond: CD_ACCEPT,
				tgt_t: ST_TAKE, tgt_f: ST_TAKE};
		endcase
	end

	logic adv;
	logic take_fire;
	logic issue_fire;
	logic last_now;
	logic cond_ok;
	logic v7_s7;

	logic [PW-1:0] i_q;
	logic [PW-1:0] j_q;
	logic [MW-1:0] m_q;

	assign adv        = !v7_s7 || magnified.ready;
	assign pixels.ready = uw.take;
	assign take_fire  = uw.take && pixels.valid;
	assign issue_fire = uw.issue && adv;
	assign last_now   = (MW'(i_q) == m_q - MW'(1)) && (MW'(j_q) == m_q - MW'(1));

	logic win_q;

	always_comb begin
		case (uw.cond)
			CD_ACCEPT: cond_ok = take_fire;
			CD_WINDOW: cond_ok = win_q;
			CD_LAST:   cond_ok = issue_fire && last_now;
			default:   cond_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= ST_TAKE;
		else
			pc_q <= cond_ok ? uw.tgt_t : uw.tgt_f;
	end

	// positions and line store
	logic [CW-1:0]             col_q;
	logic [bim_pkg::POS_W-1:0] row_q;
	logic [CW-1:0]             col_eff;
	logic [bim_pkg::POS_W-1:0] row_eff;
	logic [CW-1:0]             col_m1;

	assign col_eff = pixels.frame_start ? '0 : col_q;
	assign row_eff = pixels.frame_start ? '0 : row_q;
	assign col_m1  = col_eff - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			win_q <= 1'b0;
		end else if (take_fire) begin
			win_q <= (row_eff != '0) && (col_eff != '0);
			if (CMP_W'(col_eff) + CMP_W'(1) >= w_eff) begin
				col_q <= '0;
				if (row_eff < bim_pkg::ROW_LIMIT)
					row_q <= row_eff + bim_pkg::POS_W'(1);
				else
					row_q <= row_eff;
			end else begin
				col_q <= col_eff + CW'(1);
				row_q <= row_eff;
			end
		end
	end

	logic [PX-1:0] line_mem [MAX_LINE_WIDTH];
	logic [PX-1:0] above_q;
	logic [PX-1:0] cur_q;
	logic [bim_pkg::POS_W-1:0] brow_q;
	logic [bim_pkg::POS_W-1:0] bcol_q;

	always_ff @(posedge clk) begin
		if (take_fire) begin
			above_q <= line_mem[col_eff];
			line_mem[col_eff] <= pixels.pixel_value;
			cur_q  <= pixels.pixel_value;
			brow_q <= row_eff - bim_pkg::POS_W'(1);
			bcol_q <= bim_pkg::POS_W'(col_m1);
		end
	end

	// neighbours and window
	logic [PX-1:0] prev_q;
	logic [PX-1:0] ul_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			ul_q   <= '0;
		end else if (uw.load) begin
			prev_q <= cur_q;
			ul_q   <= above_q;
		end
	end

	logic [PX-1:0]                tl_q, tr_q, bl_q, br_q;
	logic [bim_pkg::WGT_W-1:0]    mm_q;
	logic [bim_pkg::RC_W-1:0]     rc_q;

	always_ff @(posedge clk) begin
		if (uw.load) begin
			tl_q <= ul_q;
			tr_q <= above_q;
			bl_q <= prev_q;
			br_q <= cur_q;
			m_q  <= mag_eff;
			mm_q <= bim_pkg::WGT_W'({3'd0, mag_eff} * {3'd0, mag_eff});
			rc_q <= bim_pkg::recip_for(mag_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else if (uw.load) begin
			i_q <= '0;
			j_q <= '0;
		end else if (issue_fire) begin
			if (MW'(j_q) == m_q - MW'(1)) begin
				j_q <= '0;
				i_q <= i_q + PW'(1);
			end else begin
				j_q <= j_q + PW'(1);
			end
		end
	end

	// weights of the current phase
	logic [MW-1:0] fi, fj, ii, jj;
	logic [bim_pkg::WGT_W-1:0] wgt [4];
	tag_t tag_now;

	always_comb begin
		ii = MW'(i_q);
		jj = MW'(j_q);
		fi = m_q - ii;
		fj = m_q - jj;
		wgt[0] = bim_pkg::WGT_W'({3'd0, fi} * {3'd0, fj});
		wgt[1] = bim_pkg::WGT_W'({3'd0, fi} * {3'd0, jj});
		wgt[2] = bim_pkg::WGT_W'({3'd0, ii} * {3'd0, fj});
		wgt[3] = bim_pkg::WGT_W'({3'd0, ii} * {3'd0, jj});
		tag_now = '{i: i_q, j: j_q, row: brow_q, col: bcol_q, last: last_now};
	end

	// datapath
	logic                       v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	tag_t                       t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	logic [PX-1:0]              px_s1 [4];
	logic [bim_pkg::WGT_W-1:0]  w_s1 [4];
	logic [bim_pkg::ACC_W-1:0]  pr_s2 [4];
	logic [bim_pkg::ACC_W-1:0]  acc_s3, acc_s4, acc_s5, acc_s6;
	logic [PP_W-1:0]            ph_s4, pl_s4;
	logic [PX-1:0]              qe_s5, qe_s6;
	logic [bim_pkg::ACC_W-1:0]  qm_s6;
	logic [PX-1:0]              q_s7;

	logic [SUM_W-1:0]           sum_c;
	logic [TOT_W-1:0]           tot_c;
	logic [bim_pkg::ACC_W-1:0]  rem_c;

	assign sum_c = SUM_W'(pr_s2[0]) + SUM_W'(pr_s2[1]) + SUM_W'(pr_s2[2])
		+ SUM_W'(pr_s2[3]) + SUM_W'(mm_q >> 1);
	assign tot_c = (TOT_W'(ph_s4) << bim_pkg::HALF_W) + TOT_W'(pl_s4);
	assign rem_c = acc_s6 - qm_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
			v7_s7 <= 1'b0;
		end else if (adv) begin
			v1_s1 <= issue_fire;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
			v6_s6 <= v5_s5;
			v7_s7 <= v6_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1[0] <= tl_q;
			px_s1[1] <= tr_q;
			px_s1[2] <= bl_q;
			px_s1[3] <= br_q;
			w_s1     <= wgt;
			t_s1     <= tag_now;

			for (int k = 0; k < 4; k++)
				pr_s2[k] <= bim_pkg::ACC_W'(px_s1[k]) * bim_pkg::ACC_W'(w_s1[k]);
			t_s2 <= t_s1;

			acc_s3 <= sum_c[bim_pkg::ACC_W-1:0];
			t_s3   <= t_s2;

			ph_s4  <= PP_W'(acc_s3[bim_pkg::ACC_W-1:bim_pkg::HALF_W]) * PP_W'(rc_q);
			pl_s4  <= PP_W'(acc_s3[bim_pkg::HALF_W-1:0]) * PP_W'(rc_q);
			acc_s4 <= acc_s3;
			t_s4   <= t_s3;

			qe_s5  <= tot_c[bim_pkg::Q_SHIFT+PX-1:bim_pkg::Q_SHIFT];
			acc_s5 <= acc_s4;
			t_s5   <= t_s4;

			qm_s6  <= bim_pkg::ACC_W'(qe_s5) * bim_pkg::ACC_W'(mm_q);
			qe_s6  <= qe_s5;
			acc_s6 <= acc_s5;
			t_s6   <= t_s5;

			q_s7 <= qe_s6 + PX'(rem_c >= bim_pkg::ACC_W'(mm_q));
			t_s7 <= t_s6;
		end
	end

	assign magnified.valid         = v7_s7;
	assign magnified.out_value     = q_s7;
	assign magnified.line_phase    = t_s7.i;
	assign magnified.sample_phase  = t_s7.j;
	assign magnified.block_line    = t_s7.row;
	assign magnified.block_sample  = t_s7.col;
	assign magnified.last_of_block = t_s7.last;

endmodule
`default_nettype wire
